[rtl/assert_macros.svh]
// Assertion helpers used by the bounded_uniform_random RTL.
// All checks sample on the rising edge of clk and are held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property check.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/bur_pkg.sv]
// ----------------------------------------------------------------------------
// bur_pkg
// Widths, register indexes and reset values for the bounded uniform random
// block and its stream interfaces.
// ----------------------------------------------------------------------------
package bur_pkg;

    // Data path word width and the serial step counter width
    localparam int WORD_W = 64;
    localparam int CNT_W  = $clog2(WORD_W);

    // Retry counter
    localparam int RETRY_W         = 4;
    localparam int MAX_RETRIES_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = CFG_IDX_W'(1);

    // Reset values of the bounds and what follows from them
    localparam logic [WORD_W-1:0] RESET_LOWER = WORD_W'(1);
    localparam logic [WORD_W-1:0] RESET_UPPER = WORD_W'(2);
    localparam logic [WORD_W-1:0] RESET_SPAN  = RESET_UPPER - RESET_LOWER + WORD_W'(1);
    localparam logic [WORD_W-1:0] RESET_THRESHOLD =
        (RESET_SPAN == '0) ? '0 : ((WORD_W'(0) - RESET_SPAN) % RESET_SPAN);

endpackage

[rtl/bur_stream_if.sv]
// ----------------------------------------------------------------------------
// bur_stream_if
// Valid/ready channels: raw random words in, bounded results out.
// ----------------------------------------------------------------------------

// Input channel: one raw random word per transaction
interface bur_in_if;
    logic                       valid;
    logic                       ready;
    logic [bur_pkg::WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// Output channel: one bounded value per transaction
interface bur_out_if;
    logic                       valid;
    logic                       ready;
    logic [bur_pkg::WORD_W-1:0] bounded_value;
    logic                       forced_accept;

    modport source (output valid, output bounded_value, output forced_accept, input ready);
    modport sink   (input valid, input bounded_value, input forced_accept, output ready);
endinterface

[rtl/bounded_uniform_random.sv]
// An accepted word runs through a bit-serial 64x64 multiply in ST_MUL, then ST_DECIDE
// registers its result (if any), waiting while the output is full; no new word is taken before ST_IDLE.
// A bound write blocks input in its own cycle and while a bit-serial restoring divider
// recomputes the threshold; a write drops any word in flight.
// Reset: bounds return to 1 and 2, threshold to its matching value, retry count
// to 0, and the output channel is emptied.
// ----------------------------------------------------------------------------
// bounded_uniform_random
// Maps 64-bit random words onto [lower_bound, upper_bound] by multiply and
// reject. Multiply and threshold division share the acc and sh shift registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_uniform_random #(
    parameter int MAX_RETRIES = bur_pkg::MAX_RETRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bur_in_if.sink                        in_ch,
    bur_out_if.source                     out_ch,
    input  logic                          cfg_wr_en,
    input  logic [bur_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [bur_pkg::WORD_W-1:0]    cfg_wr_data
);

    localparam int W = bur_pkg::WORD_W;
    localparam logic [bur_pkg::RETRY_W-1:0] RETRY_LIMIT = bur_pkg::RETRY_W'(MAX_RETRIES);

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SPAN     = 3'd1;
    localparam logic [2:0] ST_DIV_INIT = 3'd2;
    localparam logic [2:0] ST_DIV      = 3'd3;
    localparam logic [2:0] ST_MUL      = 3'd4;
    localparam logic [2:0] ST_DECIDE   = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [W-1:0]                    lower_reg, lower_next;
    logic [W-1:0]                    upper_reg, upper_next;
    logic [W-1:0]                    span_reg, span_next;
    logic [W-1:0]                    thresh_reg, thresh_next;
    logic [bur_pkg::RETRY_W-1:0]     rej_count_reg, rej_count_next;
    logic [W-1:0]                    acc_reg, acc_next;
    logic [W-1:0]                    sh_reg, sh_next;
    logic [bur_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [W-1:0]                    out_value_reg, out_value_next;
    logic                            out_forced_reg, out_forced_next;

    logic                            cfg_hit;
    logic [W:0]                      div_trial;
    logic [W:0]                      mul_sum;
    logic                            below;
    logic                            retry_ok;
    logic                            slot_free;

    // Serial step helpers
    assign cfg_hit   = cfg_wr_en && ((cfg_wr_index == bur_pkg::REG_LOWER_BOUND) ||
                                     (cfg_wr_index == bur_pkg::REG_UPPER_BOUND));
    assign div_trial = {acc_reg, sh_reg[W-1]};
    assign mul_sum   = {1'b0, acc_reg} + (sh_reg[0] ? {1'b0, span_reg} : '0);
    assign below     = sh_reg < thresh_reg;
    assign retry_ok  = rej_count_reg < RETRY_LIMIT;
    assign slot_free = !out_valid_reg || out_ch.ready;

    // Sequencer and data path
    always_comb
    begin
        state_next      = state_reg;
        lower_next      = lower_reg;
        upper_next      = upper_reg;
        span_next       = span_reg;
        thresh_next     = thresh_reg;
        rej_count_next  = rej_count_reg;
        acc_next        = acc_reg;
        sh_next         = sh_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_value_next  = out_value_reg;
        out_forced_next = out_forced_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    acc_next   = '0;
                    sh_next    = in_ch.random_word;
                    cnt_next   = bur_pkg::CNT_W'(W - 1);
                    state_next = ST_MUL;
                end
            end
            ST_SPAN:
            begin
                span_next  = upper_reg - lower_reg + W'(1);
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                // Dividend is 2^64 - s taken mod 2^64
                acc_next   = '0;
                sh_next    = W'(0) - span_reg;
                cnt_next   = bur_pkg::CNT_W'(W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // One restoring division step per cycle
                if (div_trial >= {1'b0, span_reg})
                    acc_next = W'(div_trial - {1'b0, span_reg});
                else
                    acc_next = div_trial[W-1:0];
                sh_next  = {sh_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - bur_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    thresh_next = acc_next;
                    state_next  = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                // Shift-add, multiplier bits consumed LSB first
                acc_next = mul_sum[W:1];
                sh_next  = {mul_sum[0], sh_reg[W-1:1]};
                cnt_next = cnt_reg - bur_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // acc holds the high half, sh the low half
                if (below && retry_ok)
                begin
                    rej_count_next = rej_count_reg + bur_pkg::RETRY_W'(1);
                    state_next     = ST_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = lower_reg + acc_reg;
                    out_forced_next = below;
                    rej_count_next  = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Bound writes restart the threshold computation
        if (cfg_hit)
        begin
            if (cfg_wr_index == bur_pkg::REG_LOWER_BOUND)
                lower_next = cfg_wr_data;
            else
                upper_next = cfg_wr_data;
            state_next = ST_SPAN;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lower_reg     <= bur_pkg::RESET_LOWER;
            upper_reg     <= bur_pkg::RESET_UPPER;
            span_reg      <= bur_pkg::RESET_SPAN;
            thresh_reg    <= bur_pkg::RESET_THRESHOLD;
            rej_count_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            span_reg      <= span_next;
            thresh_reg    <= thresh_next;
            rej_count_reg <= rej_count_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        sh_reg         <= sh_next;
        out_value_reg  <= out_value_next;
        out_forced_reg <= out_forced_next;
    end

    // Ports; no word is taken in a cycle that writes a bound
    assign in_ch.ready          = (state_reg == ST_IDLE) && !cfg_hit;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.bounded_value = out_value_reg;
    assign out_ch.forced_accept = out_forced_reg;

    // Checks
    `ASSERT_CLK(a_accept_starts_mul,
        (in_ch.valid && in_ch.ready && !cfg_hit) |=> (state_reg == ST_MUL),
        "accepted word did not start the multiply")
    `ASSERT_CLK(a_cfg_restarts_div,
        cfg_hit |=> (state_reg == ST_SPAN),
        "bound write did not restart the threshold computation")
    `ASSERT_NEVER(a_retry_bound,
        rej_count_reg > RETRY_LIMIT,
        "rejection count passed the retry limit")
    `ASSERT_CLK(a_forced_at_limit,
        (state_reg == ST_DECIDE && below && !retry_ok && slot_free) |=>
            (out_ch.valid && out_ch.forced_accept),
        "word at the retry limit was not forced through")

endmodule

[tb/bounded_uniform_random_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_uniform_random_test
// Self-checking bench for the bounded uniform random block. A scoreboard
// object mirrors the bounds, the rejection threshold and the retry count. It
// predicts each result from the accepted random words and compares it with
// what comes out. A short directed pass covers the corner cases. Randomized
// phases with varied bounds, runs of rejected words and random flow control
// on both channels follow it.
// ----------------------------------------------------------------------------
module bounded_uniform_random_test;

    localparam int WORD_W    = bur_pkg::WORD_W;
    localparam int CFG_IDX_W = bur_pkg::CFG_IDX_W;
    localparam int RETRY_W   = bur_pkg::RETRY_W;

    localparam logic [WORD_W-1:0]    RESET_LOWER     = bur_pkg::RESET_LOWER;
    localparam logic [WORD_W-1:0]    RESET_UPPER     = bur_pkg::RESET_UPPER;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = bur_pkg::REG_LOWER_BOUND;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = bur_pkg::REG_UPPER_BOUND;

    localparam int RETRY_LIMIT     = bur_pkg::MAX_RETRIES_DEF;
    localparam int DRAIN_CYCLES    = 80;
    localparam int NUM_PHASES      = 12;
    localparam int WORDS_PER_PHASE = 75;

    // Unmapped register indexes; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] WORD_MSB = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [WORD_W-1:0] bounded_value;
        logic              forced_accept;
    } bounded_result_t;

    // Predicts bounded values and holds them until the block produces them
    class bound_scoreboard;
        logic [WORD_W-1:0]  lower_bound;
        logic [WORD_W-1:0]  upper_bound;
        logic [WORD_W-1:0]  threshold;
        logic [RETRY_W-1:0] retries;
        bounded_result_t    expected_q[$];
        int                 errors;

        function new();
            lower_bound = RESET_LOWER;
            upper_bound = RESET_UPPER;
            retries     = '0;
            errors      = 0;
            refresh_threshold();
        endfunction

        // Span wraps modulo 2^64; zero stands for the full range
        function logic [WORD_W-1:0] span();
            return upper_bound - lower_bound + WORD_W'(1);
        endfunction

        function void refresh_threshold();
            logic [WORD_W-1:0] s;
            s = span();
            threshold = (s == '0) ? '0 : ((WORD_W'(0) - s) % s);
        endfunction

        function logic [2*WORD_W-1:0] product(logic [WORD_W-1:0] word);
            return {{WORD_W{1'b0}}, word} * {{WORD_W{1'b0}}, span()};
        endfunction

        // Bound write; the retry count survives it
        function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                REG_LOWER_BOUND:
                begin
                    lower_bound = data;
                    refresh_threshold();
                end
                REG_UPPER_BOUND:
                begin
                    upper_bound = data;
                    refresh_threshold();
                end
                default:
                begin
                end
            endcase
        endfunction

        // One accepted word: either rejected (count rises) or one result
        function void note_word(logic [WORD_W-1:0] word);
            logic [2*WORD_W-1:0] p;
            logic                below;
            p     = product(word);
            below = p[WORD_W-1:0] < threshold;
            if (below && retries < RETRY_LIMIT)
            begin
                retries = retries + 1'b1;
                return;
            end
            expected_q.push_back('{lower_bound + p[2*WORD_W-1:WORD_W], below});
            retries = '0;
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [WORD_W-1:0] value, logic forced);
            bounded_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", value));
                return;
            end
            exp_r = expected_q.pop_front();
            if (value !== exp_r.bounded_value)
                report_mismatch($sformatf("bounded_value %h, expected %h",
                                          value, exp_r.bounded_value));
            if (forced !== exp_r.forced_accept)
                report_mismatch($sformatf("forced_accept %b, expected %b",
                                          forced, exp_r.forced_accept));
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // A word whose low product half falls below the threshold, if one turns up
        function logic [WORD_W-1:0] rejected_word();
            logic [WORD_W-1:0]   word;
            logic [2*WORD_W-1:0] p;
            for (int k = 0; k < 64; k++)
            begin
                word = {$urandom, $urandom};
                p    = product(word);
                if (p[WORD_W-1:0] < threshold)
                    return word;
            end
            return '0;
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [WORD_W-1:0]    cfg_wr_data;
    logic                 stalls_on;
    bit                   gaps_on;
    int                   stall_left = 0;
    bound_scoreboard      results_sb;

    bur_in_if  in_ch();
    bur_out_if out_ch();

    bounded_uniform_random #(
        .MAX_RETRIES (RETRY_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output back-pressure: mostly short stalls, a few long ones
    always @(posedge clk)
    begin
        if (!stalls_on)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                          : $urandom_range(1, 4);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            results_sb.check_result(out_ch.bounded_value, out_ch.forced_accept);
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] edge_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return WORD_MAX;
            2:       return WORD_W'(1);
            3:       return WORD_MSB;
            4:       return WORD_MAX - WORD_W'(1);
            default: return WORD_W'(1) << $urandom_range(0, WORD_W-1);
        endcase
    endfunction

    function automatic int input_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 100);
    endfunction

    // One input transaction; valid stays high when the next word follows at once
    task automatic send_word(input logic [WORD_W-1:0] word);
        int gap;
        gap = input_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.random_word <= word;
        do
            @(posedge clk);
        while (!in_ch.ready);
        results_sb.note_word(word);
    endtask

    task automatic send_repeat(input logic [WORD_W-1:0] word, input int count);
        repeat (count) send_word(word);
    endtask

    // Stop input, let all results out and give a rejected word time to finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (results_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge clk);
        results_sb.set_bound(idx, data);
    endtask

    // Both bounds in random order, optionally with a write to an unmapped index
    task automatic write_bounds(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                                input bit with_spare);
        if (with_spare)
            cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3, rand_word());
        if ($urandom_range(0, 1) == 0)
        begin
            cfg_write(REG_LOWER_BOUND, lo);
            cfg_write(REG_UPPER_BOUND, hi);
        end
        else
        begin
            cfg_write(REG_UPPER_BOUND, hi);
            cfg_write(REG_LOWER_BOUND, lo);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Bounds for one random phase, by flavor
    task automatic pick_bounds(input int kind, output logic [WORD_W-1:0] lo,
                               output logic [WORD_W-1:0] hi);
        lo = rand_word();
        case (kind)
            0: hi = rand_word();
            1:
            begin
                lo = '0;
                hi = WORD_MAX;
            end
            // span just above 2^63: about half of all words are rejected
            2: hi = lo + WORD_MSB + WORD_W'($urandom_range(0, 1000));
            3: hi = lo + WORD_W'($urandom_range(0, 1000));
            // upper below lower: span wraps
            4: hi = lo - WORD_W'($urandom_range(1, 1000));
            // power-of-two span: nothing is ever rejected
            5: hi = lo + (WORD_W'(1) << $urandom_range(0, WORD_W-1)) - WORD_W'(1);
            6:
            begin
                lo = WORD_MAX - WORD_W'($urandom_range(0, 100));
                hi = WORD_MAX;
            end
            default:
            begin
                lo = '0;
                hi = rand_word() >> $urandom_range(0, WORD_W-1);
            end
        endcase
    endtask

    // Stimulus and final verdict
    initial
    begin
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        int                sent;
        int                run_len;

        results_sb = new();
        in_ch.valid       <= 1'b0;
        in_ch.random_word <= '0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_index      <= '0;
        cfg_wr_data       <= '0;
        stalls_on         <= 1'b0;
        gaps_on = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset bounds, span of two
        send_word('0);
        send_word(WORD_MAX);
        send_word(WORD_MSB);

        // Full range: result is always the lower bound
        settle();
        write_bounds('0, WORD_MAX, 1'b0);
        send_word('0);
        send_word(WORD_MAX);
        send_word(rand_word());

        // Span of three: eight rejections, then a forced accept
        settle();
        stalls_on <= 1'b1;
        cfg_write(REG_SPARE_3, WORD_MAX);
        write_bounds(WORD_W'(5), WORD_W'(7), 1'b1);
        send_repeat('0, RETRY_LIMIT + 1);
        send_word(WORD_MAX);

        // Lower at the top, upper at zero: span two, sum wraps
        settle();
        write_bounds(WORD_MAX, '0, 1'b0);
        send_word(WORD_MAX);
        send_word(WORD_MSB - WORD_W'(1));

        // Rejections left pending across a bound change
        settle();
        write_bounds(WORD_W'(10), WORD_MSB + WORD_W'(10), 1'b0);
        send_repeat('0, 3);
        settle();
        write_bounds(WORD_W'(100), WORD_W'(50), 1'b0);
        send_repeat('0, RETRY_LIMIT - 2);
        send_word(WORD_MAX);

        // Randomized phases
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            gaps_on = (ph % 3 != 2);
            stalls_on <= (ph % 3 != 2);
            pick_bounds((ph < 8) ? ph : $urandom_range(0, 7), lo, hi);
            write_bounds(lo, hi, $urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                if (results_sb.threshold != '0 && $urandom_range(0, 99) < 40)
                begin
                    // run of rejected words, long enough at times to force acceptance
                    run_len = $urandom_range(1, 12);
                    repeat (run_len) send_word(results_sb.rejected_word());
                    sent += run_len;
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(edge_word());
                    else
                        send_word(rand_word());
                    sent++;
                end
            end
        end

        settle();
        if (results_sb.errors == 0 && results_sb.pending() == 0)
            $display("bounded_uniform_random regression: pass");
        else
            $display("bounded_uniform_random regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30_000_000;
        $display("bounded_uniform_random regression: fail");
        $finish;
    end

endmodule
